// ===== design/qpps_pkg.sv =====
package qpps_pkg;

  // Item kinds carried on in_tuser
  localparam logic [1:0] OP_EDGE_A = 2'd0;
  localparam logic [1:0] OP_EDGE_B = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  // Configuration register indexes
  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] REG_KP      = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_KI      = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_KD      = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_PWM_MAX = 2'd3;

  // Field and state widths
  localparam int GAIN_W   = 16;
  localparam int DUTY_W   = 8;
  localparam int REF_W    = 24;
  localparam int ERR_W    = 25;
  localparam int INT_W    = 32;
  localparam int CFG_W    = 16;
  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 40;

  localparam int POSITION_BITS_DEF = 24;

  // Reset values of the configuration registers
  localparam logic [GAIN_W-1:0] KP_RST      = 16'd256;
  localparam logic [GAIN_W-1:0] KI_RST      = 16'd0;
  localparam logic [GAIN_W-1:0] KD_RST      = 16'd0;
  localparam logic [DUTY_W-1:0] PWM_MAX_RST = 8'd100;

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
    logic [DUTY_W-1:0] pwm_max;
  } cfg_t;

endpackage

// ===== design/qpps_cfg_regs.sv =====
module qpps_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [qpps_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [qpps_pkg::CFG_W-1:0]        cfg_wdata,
  output qpps_pkg::cfg_t                    cfg
);

  qpps_pkg::cfg_t cfg_r;

  // Gain and limit registers, written one at a time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp      <= qpps_pkg::KP_RST;
      cfg_r.ki      <= qpps_pkg::KI_RST;
      cfg_r.kd      <= qpps_pkg::KD_RST;
      cfg_r.pwm_max <= qpps_pkg::PWM_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        qpps_pkg::REG_KP:      cfg_r.kp      <= cfg_wdata;
        qpps_pkg::REG_KI:      cfg_r.ki      <= cfg_wdata;
        qpps_pkg::REG_KD:      cfg_r.kd      <= cfg_wdata;
        qpps_pkg::REG_PWM_MAX: cfg_r.pwm_max <= cfg_wdata[qpps_pkg::DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== design/qpps_pid_math.sv =====
module qpps_pid_math #(
  parameter int POSITION_BITS = qpps_pkg::POSITION_BITS_DEF
) (
  input  qpps_pkg::cfg_t                          cfg,
  input  logic signed [qpps_pkg::REF_W-1:0]       reference,
  input  logic signed [POSITION_BITS-1:0]         pos,
  input  logic signed [qpps_pkg::INT_W-1:0]       integral,
  input  logic signed [qpps_pkg::ERR_W-1:0]       slope,
  input  logic signed [qpps_pkg::ERR_W-1:0]       last_error,
  output logic [qpps_pkg::DUTY_W-1:0]             mag,
  output logic                                    err_pos,
  output logic signed [qpps_pkg::INT_W-1:0]       integral_nxt,
  output logic signed [qpps_pkg::ERR_W-1:0]       slope_nxt,
  output logic signed [qpps_pkg::ERR_W-1:0]       error_nxt
);

  localparam int ERR_W = qpps_pkg::ERR_W;
  localparam int INT_W = qpps_pkg::INT_W;
  localparam int DW    = (POSITION_BITS > qpps_pkg::REF_W ?
                          POSITION_BITS : qpps_pkg::REF_W) + 1;
  localparam int PW    = ERR_W + qpps_pkg::GAIN_W + 1;
  localparam int IPW   = INT_W + qpps_pkg::GAIN_W + 1;
  localparam int UW    = IPW + 2;
  localparam int SW    = UW - 8;

  logic signed [DW-1:0]    diff;
  logic signed [ERR_W-1:0] err;
  logic signed [PW-1:0]    p_prod;
  logic signed [IPW-1:0]   i_prod;
  logic signed [PW-1:0]    d_prod;
  logic signed [UW-1:0]    u;
  logic [UW-1:0]           u_abs;
  logic [SW-1:0]           u_shr;
  logic signed [INT_W:0]   isum;
  logic signed [ERR_W:0]   sdiff;

  // Error, saturated to the error width
  assign diff = DW'(reference) - DW'(pos);

  always_comb begin
    if (diff[DW-1:ERR_W-1] == '0 || diff[DW-1:ERR_W-1] == '1) begin
      err = diff[ERR_W-1:0];
    end else begin
      err = diff[DW-1] ? {1'b1, {(ERR_W-1){1'b0}}} : {1'b0, {(ERR_W-1){1'b1}}};
    end
  end

  // P, I and D products, Q8.8
  assign p_prod = err * $signed({1'b0, cfg.kp});
  assign i_prod = integral * $signed({1'b0, cfg.ki});
  assign d_prod = slope * $signed({1'b0, cfg.kd});
  assign u      = UW'(p_prod) + UW'(i_prod) + UW'(d_prod);

  // Magnitude, drop the fraction, clamp to the duty limit
  assign u_abs = u[UW-1] ? UW'(-u) : UW'(u);
  assign u_shr = u_abs[UW-1:8];
  assign mag   = (u_shr > SW'(cfg.pwm_max)) ? cfg.pwm_max : u_shr[qpps_pkg::DUTY_W-1:0];

  assign err_pos = !err[ERR_W-1] && (err != '0);

  // Integral update, saturating
  assign isum = (INT_W+1)'(integral) + (INT_W+1)'(err);
  always_comb begin
    if (isum[INT_W] != isum[INT_W-1]) begin
      integral_nxt = isum[INT_W] ? {1'b1, {(INT_W-1){1'b0}}} : {1'b0, {(INT_W-1){1'b1}}};
    end else begin
      integral_nxt = isum[INT_W-1:0];
    end
  end

  // Slope update, saturating
  assign sdiff = (ERR_W+1)'(err) - (ERR_W+1)'(last_error);
  always_comb begin
    if (sdiff[ERR_W] != sdiff[ERR_W-1]) begin
      slope_nxt = sdiff[ERR_W] ? {1'b1, {(ERR_W-1){1'b0}}} : {1'b0, {(ERR_W-1){1'b1}}};
    end else begin
      slope_nxt = sdiff[ERR_W-1:0];
    end
  end

  assign error_nxt = err;

endmodule

// ===== design/quadrature_position_pid_servo.sv =====
// Quadrature position counter with a PID servo. Each input item is an encoder
// edge (channel A or B, with both channel levels) or a control tick carrying a
// reference position; every item gives exactly one result with the position
// after the item and the held up/down drive duties. The block takes one item
// per clock cycle, back to back, while the result side is not stalled. An item
// accepted sits in the input register; it moves on when the result register is
// free or being taken, its result is then loaded into the result register and
// out_tvalid rises. A stalled result side holds the input register and
// then in_tready. The tick path (error, three Q8.8 gain multiplies, sum,
// clamp) sits between these two registers and sets the clock rate. Gains and
// pwm_max may only be written while no item is in flight.
module quadrature_position_pid_servo #(
  parameter int POSITION_BITS = qpps_pkg::POSITION_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input channel
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [qpps_pkg::IN_TDATA_W-1:0]      in_tdata,  // a_level, b_level, reference[23:0]
  input  logic [qpps_pkg::IN_TUSER_W-1:0]      in_tuser,  // operation[1:0]
  // result channel
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [qpps_pkg::OUT_TDATA_W-1:0]     out_tdata, // position[23:0], drive_up, drive_down
  // configuration
  input  logic                                 cfg_we,
  input  logic [qpps_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [qpps_pkg::CFG_W-1:0]           cfg_wdata
);

  localparam int REF_W  = qpps_pkg::REF_W;
  localparam int ERR_W  = qpps_pkg::ERR_W;
  localparam int INT_W  = qpps_pkg::INT_W;
  localparam int DUTY_W = qpps_pkg::DUTY_W;

  qpps_pkg::cfg_t cfg;

  // Input stage
  logic                    s1_valid_r;
  logic [1:0]              s1_op_r;
  logic                    s1_a_r;
  logic                    s1_b_r;
  logic signed [REF_W-1:0] s1_ref_r;
  logic                    s1_go;

  // Servo state
  logic signed [POSITION_BITS-1:0] count_r,      count_nxt;
  logic signed [INT_W-1:0]         integral_r;
  logic signed [ERR_W-1:0]         slope_r;
  logic signed [ERR_W-1:0]         last_error_r;
  logic [DUTY_W-1:0]               held_up_r,    held_up_nxt;
  logic [DUTY_W-1:0]               held_down_r,  held_down_nxt;

  // Result stage
  logic                    out_valid_r;
  logic [REF_W-1:0]        out_pos_r;
  logic [DUTY_W-1:0]       out_up_r;
  logic [DUTY_W-1:0]       out_down_r;

  // PID math outputs
  logic [DUTY_W-1:0]       mag;
  logic                    err_pos;
  logic signed [INT_W-1:0] integral_nxt;
  logic signed [ERR_W-1:0] slope_nxt;
  logic signed [ERR_W-1:0] error_nxt;

  logic is_edge;
  logic is_tick;
  logic step_up;

  qpps_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Handshake: the input stage moves on whenever the result register is free or being taken
  assign s1_go     = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_op_r  <= in_tuser[1:0];
      s1_a_r   <= in_tdata[0];
      s1_b_r   <= in_tdata[1];
      s1_ref_r <= in_tdata[REF_W+1:2];
    end
  end

  // Encoder step
  assign is_edge = (s1_op_r == qpps_pkg::OP_EDGE_A) || (s1_op_r == qpps_pkg::OP_EDGE_B);
  assign is_tick = (s1_op_r == qpps_pkg::OP_TICK);
  assign step_up = (s1_op_r == qpps_pkg::OP_EDGE_A) ? (s1_a_r == s1_b_r) : (s1_a_r != s1_b_r);

  always_comb begin
    count_nxt = count_r;
    if (is_edge) begin
      count_nxt = step_up ? count_r + POSITION_BITS'(1) : count_r - POSITION_BITS'(1);
    end
  end

  qpps_pid_math #(
    .POSITION_BITS (POSITION_BITS)
  ) u_pid (
    .cfg          (cfg),
    .reference    (s1_ref_r),
    .pos          (count_r),
    .integral     (integral_r),
    .slope        (slope_r),
    .last_error   (last_error_r),
    .mag          (mag),
    .err_pos      (err_pos),
    .integral_nxt (integral_nxt),
    .slope_nxt    (slope_nxt),
    .error_nxt    (error_nxt)
  );

  // Drive duties: new on a tick, held otherwise
  always_comb begin
    held_up_nxt   = held_up_r;
    held_down_nxt = held_down_r;
    if (is_tick) begin
      held_up_nxt   = err_pos ? mag : '0;
      held_down_nxt = err_pos ? '0 : mag;
    end
  end

  // State update when the item leaves the input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      integral_r   <= '0;
      slope_r      <= '0;
      last_error_r <= '0;
      held_up_r    <= '0;
      held_down_r  <= '0;
    end else if (s1_go) begin
      count_r     <= count_nxt;
      held_up_r   <= held_up_nxt;
      held_down_r <= held_down_nxt;
      if (is_tick) begin
        integral_r   <= integral_nxt;
        slope_r      <= slope_nxt;
        last_error_r <= error_nxt;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_pos_r  <= REF_W'(count_nxt);
      out_up_r   <= held_up_nxt;
      out_down_r <= held_down_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_down_r, out_up_r, out_pos_r};

endmodule

// ===== verif/servo_checker.sv =====
// Watches the servo's channels, keeps its own copy of the encoder count, the
// loop state and the gains, and compares every result with the oldest
// prediction.
module servo_checker #(
  parameter int POSITION_BITS = qpps_pkg::POSITION_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  input  logic                               in_tready,
  input  logic [qpps_pkg::IN_TDATA_W-1:0]    in_tdata,  // a_level, b_level, reference[23:0]
  input  logic [qpps_pkg::IN_TUSER_W-1:0]    in_tuser,  // operation[1:0]
  input  logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic [qpps_pkg::OUT_TDATA_W-1:0]   out_tdata, // position[23:0], drive_up, drive_down
  input  logic                               cfg_we,
  input  logic [qpps_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [qpps_pkg::CFG_W-1:0]         cfg_wdata,
  output int                                 fail_count,
  output int                                 pending
);
  import qpps_pkg::*;

  localparam int MAX_REPORTS = 10;

  // one result item; first member sits in the top bits
  typedef struct packed {
    logic [DUTY_W-1:0] drive_down;
    logic [DUTY_W-1:0] drive_up;
    logic [REF_W-1:0]  position;
  } servo_result_t;

  // mirrored gains and loop state
  cfg_t                           gains;
  logic signed [POSITION_BITS-1:0] enc_count;
  logic signed [INT_W-1:0]        err_sum;
  logic signed [ERR_W-1:0]        err_slope;
  logic signed [ERR_W-1:0]        prev_err;
  logic [DUTY_W-1:0]              duty_up;
  logic [DUTY_W-1:0]              duty_down;
  servo_result_t                  servo_results_q[$];

  function automatic longint clamp_signed(longint x, int w);
    longint hi;
    longint lo;
    hi = (longint'(1) << (w - 1)) - 1;
    lo = -hi - 1;
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  // advance the mirrored servo by one item and return what it reports
  function automatic servo_result_t servo_predict(logic [IN_TUSER_W-1:0] op,
                                                  logic [IN_TDATA_W-1:0] data);
    logic                    a_lvl;
    logic                    b_lvl;
    logic signed [REF_W-1:0] target;
    longint                  pos;
    longint                  err;
    longint                  drive;
    longint                  mag;
    longint                  gp;
    longint                  gi;
    longint                  gd;
    longint                  limit;
    servo_result_t           r;
    a_lvl  = data[0];
    b_lvl  = data[1];
    target = data[2 +: REF_W];
    pos    = longint'(enc_count);
    if (op == OP_EDGE_A || op == OP_EDGE_B) begin
      // A edge counts up on equal levels, B edge on differing levels
      if ((op == OP_EDGE_A) ? (a_lvl == b_lvl) : (a_lvl != b_lvl))
        enc_count = enc_count + POSITION_BITS'(1);
      else
        enc_count = enc_count - POSITION_BITS'(1);
      pos = longint'(enc_count);
    end else if (op == OP_TICK) begin
      gp    = longint'(gains.kp);
      gi    = longint'(gains.ki);
      gd    = longint'(gains.kd);
      limit = longint'(gains.pwm_max);
      err   = clamp_signed(longint'(target) - pos, ERR_W);
      // P, I and D use the integral and slope of the previous tick
      drive = err * gp + longint'(err_sum) * gi + longint'(err_slope) * gd;
      mag   = (drive < 0) ? -drive : drive;
      mag   = mag >> 8;
      if (mag > limit) mag = limit;
      if (err > 0) begin
        duty_up   = mag[DUTY_W-1:0];
        duty_down = '0;
      end else begin
        duty_up   = '0;
        duty_down = mag[DUTY_W-1:0];
      end
      err_sum   = INT_W'(clamp_signed(longint'(err_sum) + err, INT_W));
      err_slope = ERR_W'(clamp_signed(err - longint'(prev_err), ERR_W));
      prev_err  = ERR_W'(err);
    end
    r.position   = pos[REF_W-1:0];
    r.drive_up   = duty_up;
    r.drive_down = duty_down;
    return r;
  endfunction

  task automatic check_field(string name, logic [REF_W-1:0] want, logic [REF_W-1:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    servo_result_t want;
    servo_result_t got;
    if (!rst_n) begin
      gains     = '{kp: KP_RST, ki: KI_RST, kd: KD_RST, pwm_max: PWM_MAX_RST};
      enc_count = '0;
      err_sum   = '0;
      err_slope = '0;
      prev_err  = '0;
      duty_up   = '0;
      duty_down = '0;
      servo_results_q.delete();
    end else begin
      // register writes are expected only while nothing is in flight; this checker does not enforce it
      if (cfg_we) begin
        case (cfg_addr)
          REG_KP:      gains.kp      = cfg_wdata[GAIN_W-1:0];
          REG_KI:      gains.ki      = cfg_wdata[GAIN_W-1:0];
          REG_KD:      gains.kd      = cfg_wdata[GAIN_W-1:0];
          REG_PWM_MAX: gains.pwm_max = cfg_wdata[DUTY_W-1:0];
          default: ;
        endcase
      end
      // compare a result item before queueing a new prediction
      if (out_tvalid && out_tready) begin
        got = servo_result_t'(out_tdata);
        if (servo_results_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: result item with nothing expected, got %0h", $time, got);
        end else begin
          want = servo_results_q.pop_front();
          check_field("position", want.position, got.position);
          check_field("drive_up", REF_W'(want.drive_up), REF_W'(got.drive_up));
          check_field("drive_down", REF_W'(want.drive_down), REF_W'(got.drive_down));
        end
      end
      if (in_tvalid && in_tready)
        servo_results_q.push_back(servo_predict(in_tuser, in_tdata));
    end
    pending = servo_results_q.size();
  end

endmodule

// ===== verif/tb.sv =====
module tb;
  import qpps_pkg::*;

  localparam logic [IN_TUSER_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [REF_W-1:0] REF_MAX = 24'h7FFFFF;
  localparam logic [REF_W-1:0] REF_MIN = 24'h800000;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int MOTION_PHASES  = 9;
  localparam int MOTION_ITEMS   = 48;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_tvalid = 1'b0;
  logic                    in_tready;
  logic [IN_TDATA_W-1:0]   in_tdata = '0;  // a_level, b_level, reference[23:0]
  logic [IN_TUSER_W-1:0]   in_tuser = '0;  // operation[1:0]
  logic                    out_tvalid;
  logic                    out_tready = 1'b1;
  logic [OUT_TDATA_W-1:0]  out_tdata;     // position[23:0], drive_up, drive_down
  logic                    cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]   cfg_addr = '0;
  logic [CFG_W-1:0]        cfg_wdata = '0;

  int fail_count;
  int pending;

  // stimulus-side view of the encoder
  logic enc_a = 1'b0;
  logic enc_b = 1'b0;
  int   pos_est = 0;
  bit   in_idle_on = 1'b0;
  bit   out_stall_on = 1'b0;
  int   stall_left = 0;
  int   idle_cycles = 0;

  quadrature_position_pid_servo u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  servo_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic bit count_rises(logic [IN_TUSER_W-1:0] op, logic a, logic b);
    return (op == OP_EDGE_A) ? (a == b) : (a != b);
  endfunction

  // result-side back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_tready <= 1'b0;
    end else if (out_stall_on && $urandom_range(0, 5) == 0) begin
      stall_left = gap_len() - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // ends the run if the channels stop moving
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(logic [IN_TUSER_W-1:0] op, logic a, logic b,
                           logic [REF_W-1:0] target);
    int gap;
    gap = (in_idle_on && $urandom_range(0, 4) == 0) ? gap_len() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(IN_TDATA_W - REF_W - 2){1'b0}}, target, b, a};
    do @(posedge clk); while (!in_tready);
    enc_a = a;
    enc_b = b;
    if (op == OP_EDGE_A || op == OP_EDGE_B)
      pos_est = count_rises(op, a, b) ? pos_est + 1 : pos_est - 1;
  endtask

  task automatic send_tick(logic [REF_W-1:0] target);
    send_item(OP_TICK, enc_a, enc_b, target);
  endtask

  // one encoder step in the given direction, following the gray sequence
  task automatic move_encoder(bit up);
    if (up == (enc_a != enc_b))
      send_item(OP_EDGE_A, ~enc_a, enc_b, '0);
    else
      send_item(OP_EDGE_B, enc_a, ~enc_b, '0);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic configure(logic [CFG_W-1:0] kp, logic [CFG_W-1:0] ki,
                           logic [CFG_W-1:0] kd, logic [CFG_W-1:0] pwm_max);
    logic [CFG_ADDR_W-1:0] addrs[4];
    logic [CFG_W-1:0]      vals[4];
    addrs = '{REG_KP, REG_KI, REG_KD, REG_PWM_MAX};
    vals  = '{kp, ki, kd, pwm_max};
    wait_drained();
    foreach (addrs[i]) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_addr  <= addrs[i];
      cfg_wdata <= vals[i];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [REF_W-1:0] pick_target();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return REF_W'(pos_est + $signed($urandom_range(0, 400)) - 200);
    if (r < 85) return REF_W'(pos_est + $signed($urandom_range(0, 131072)) - 65536);
    return REF_W'($urandom());
  endfunction

  // encoder motion in runs, with ticks and some out-of-sequence items mixed in
  task automatic drive_motion(int n_items);
    int  run_left;
    bit  heading;
    int  r;
    run_left = 0;
    heading  = 1'b1;
    repeat (n_items) begin
      if (run_left == 0) begin
        run_left = $urandom_range(1, 20);
        heading  = 1'($urandom_range(0, 1));
      end
      r = $urandom_range(0, 99);
      if (r < 14) begin
        send_tick(pick_target());
      end else if (r < 20) begin
        send_item(IN_TUSER_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), REF_W'($urandom()));
      end else begin
        move_encoder(heading);
        run_left--;
      end
    end
  endtask

  // long run of ticks far from the count, to push the integral into its rail
  task automatic drive_windup(int n_items, bit to_negative);
    logic [REF_W-1:0] target;
    repeat (n_items) begin
      if ($urandom_range(0, 15) == 0) begin
        move_encoder(1'($urandom_range(0, 1)));
      end else begin
        target = to_negative ? REF_MIN + REF_W'($urandom_range(0, 1000))
                             : REF_MAX - REF_W'($urandom_range(0, 1000));
        send_tick(target);
      end
    end
  endtask

  initial begin
    logic [CFG_W-1:0] kp_sel;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: edge rules, unused code, drive sign and clamp at reset gains
    send_item(OP_EDGE_A, 1'b1, 1'b1, '0);
    send_item(OP_EDGE_A, 1'b0, 1'b0, '0);
    send_item(OP_EDGE_A, 1'b1, 1'b0, '0);
    send_item(OP_EDGE_A, 1'b0, 1'b1, '0);
    send_item(OP_EDGE_B, 1'b1, 1'b0, '0);
    send_item(OP_EDGE_B, 1'b0, 1'b1, '0);
    send_item(OP_EDGE_B, 1'b1, 1'b1, '0);
    send_item(OP_EDGE_B, 1'b0, 1'b0, '0);
    send_item(OP_UNUSED, 1'b1, 1'b1, REF_MAX);
    send_tick('0);
    send_tick(24'd3);
    send_tick(-24'sd7);
    send_tick(REF_MAX);
    send_tick(REF_MIN);
    send_item(OP_EDGE_A, 1'b1, 1'b1, '0);
    send_tick(24'd1);
    // zero duty limit forces both drives low
    configure(16'd256, 16'd0, 16'd0, 16'd0);
    send_tick(REF_MAX);
    send_tick(REF_MIN);
    // integral and slope terms in play
    configure(16'd256, 16'd256, 16'd256, 16'd255);
    send_tick(24'd10);
    send_tick(-24'sd10);
    send_tick('0);

    // random motion over a range of gain settings
    for (int p = 0; p < MOTION_PHASES; p++) begin
      kp_sel = ($urandom_range(0, 1) == 1) ? CFG_W'($urandom_range(0, 1024))
                                           : CFG_W'($urandom());
      case (p)
        0: configure(16'd0, 16'd0, 16'd0, 16'd255);
        1: configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd255);
        2: configure(16'd256, 16'd0, 16'd0, 16'd1);
        3: configure(kp_sel, CFG_W'($urandom_range(0, 64)),
                     CFG_W'($urandom()), 16'd0);
        default: configure(kp_sel, CFG_W'($urandom_range(0, 512)),
                           CFG_W'($urandom()), CFG_W'($urandom()));
      endcase
      in_idle_on   = (p % 3) != 0;
      out_stall_on = (p % 2) != 0;
      drive_motion(MOTION_ITEMS);
    end

    // integral saturation at both rails
    configure(CFG_W'($urandom_range(0, 1024)), CFG_W'($urandom_range(1, 65535)),
              CFG_W'($urandom()), 16'd255);
    in_idle_on   = 1'b1;
    out_stall_on = 1'b1;
    drive_windup(320, 1'b1);
    drive_windup(600, 1'b0);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/qpps_pkg.sv
design/qpps_cfg_regs.sv
design/qpps_pid_math.sv
design/quadrature_position_pid_servo.sv
verif/servo_checker.sv
verif/tb.sv
